FILE: sv/sqfs_pkg.sv
// ----------------------------------------------------------------------------
// sqfs_pkg: shared constants for the square-free split block
// Field widths, default value-path width and the first trial divisor.
// ----------------------------------------------------------------------------
package sqfs_pkg;

   localparam int VALUE_IN_W      = 31;  // width of the request value port
   localparam int FACTOR_W        = 16;  // width of the outside factor port
   localparam int RADICAND_W      = 31;  // width of the radicand port
   localparam int DEF_VALUE_WIDTH = 31;  // default width of the value path
   localparam int FIRST_DIVISOR   = 2;

endpackage

FILE: sv/sqfs_div.sv
// ----------------------------------------------------------------------------
// sqfs_div: iterative restoring divider
// One quotient bit per cycle; done pulses once per division.
// ----------------------------------------------------------------------------
module sqfs_div
   import sqfs_pkg::*;
#(
   parameter int W = DEF_VALUE_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic         rem_zero
);

   localparam int CW = $clog2(W);

   typedef enum logic {DV_IDLE, DV_RUN} div_state_type;

   div_state_type  state_ff;
   logic           done_ff;
   logic [CW-1:0]  count_ff;
   logic [W-1:0]   quot_ff;
   logic [W-1:0]   rem_ff;
   logic [W-1:0]   divisor_ff;

   logic [W:0]     trial;
   logic [W:0]     diff;
   logic           ge;
   logic [W-1:0]   rem_in;

   // shift next dividend bit into the partial remainder, subtract if it fits
   assign trial  = {rem_ff, quot_ff[W-1]};
   assign diff   = trial - {1'b0, divisor_ff};
   assign ge     = (trial >= {1'b0, divisor_ff});
   assign rem_in = ge ? diff[W-1:0] : trial[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               if (count_ff == '0) begin
                  state_ff <= DV_IDLE;
                  done_ff  <= 1'b1;
               end
            end
            default: begin
               state_ff <= DV_IDLE;
            end
         endcase
      end

      if (state_ff == DV_IDLE && start) begin
         quot_ff    <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
         count_ff   <= CW'(W - 1);
      end else if (state_ff == DV_RUN) begin
         quot_ff  <= {quot_ff[W-2:0], ge};
         rem_ff   <= rem_in;
         count_ff <= count_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quot     = quot_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

FILE: sv/square_free_split.sv
// ----------------------------------------------------------------------------
// square_free_split: n = a*a*b with b square-free (sqrt(n) -> a*sqrt(b))
// Trial division by d*d, d counting up from 2, on a shared multiplier and an
// iterative divider.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+----------------------
//  request   | req_value_in                               | start & !busy
//  response  | rsp_outside_factor, rsp_inside_radicand    | rsp_strobe, 1 cycle
//
// Steps: per trial divisor that does not divide, a square, a compare and a
//   divide; per square factor removed, a compare, a divide and a scale.
//   The worst case is set by the bit-serial divider inside the trial loop.
// busy is high from the accepted transaction until the response strobe;
//   the strobe cycle already accepts the next transaction.
// Reset is synchronous and clears the sequencer and the strobe only.
// The receiver cannot stall: each response is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module square_free_split
   import sqfs_pkg::*;
#(
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_IN_W-1:0] req_value_in,
   output logic                  rsp_strobe,
   output logic [FACTOR_W-1:0]   rsp_outside_factor,
   output logic [RADICAND_W-1:0] rsp_inside_radicand
);

   // d never exceeds 2^ceil(VALUE_WIDTH/2); one spare bit holds that value
   localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
   localparam int SW = 2 * DW;
   localparam int IXW = VALUE_WIDTH + VALUE_IN_W;
   localparam int FXW = DW + FACTOR_W;
   localparam int RXW = VALUE_WIDTH + RADICAND_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,   // sq = d*d on the shared multiplier
      ST_CHECK,    // loop test d*d <= rest, launch the divider
      ST_DIV,      // wait for rest / sq
      ST_SCALE     // outside = outside*d on the shared multiplier
   } state_type;

   state_type               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  rest_ff, rest_in;
   logic [DW-1:0]           d_ff, d_in;
   logic [SW-1:0]           sq_ff, sq_in;
   logic [DW-1:0]           outside_ff, outside_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [FACTOR_W-1:0]     rsp_factor_ff, rsp_factor_in;
   logic [RADICAND_W-1:0]   rsp_radicand_ff, rsp_radicand_in;

   logic [IXW-1:0]          req_ext;
   logic [FXW-1:0]          factor_ext;
   logic [RXW-1:0]          radicand_ext;
   logic [DW-1:0]           mul_a;
   logic [SW-1:0]           mul_p;
   logic                    sq_fits;
   logic                    div_start;
   logic                    div_done;
   logic [VALUE_WIDTH-1:0]  div_quot;
   logic                    div_rem_zero;

   // bits of the request above VALUE_WIDTH are dropped, missing ones are zero
   assign req_ext      = IXW'(req_value_in);
   assign factor_ext   = FXW'(outside_ff);
   assign radicand_ext = RXW'(rest_ff);

   // shared multiplier: d*d while squaring, outside*d while scaling
   assign mul_a   = (state_ff == ST_SCALE) ? outside_ff : d_ff;
   assign mul_p   = SW'(mul_a) * SW'(d_ff);

   assign sq_fits = (sq_ff <= SW'(rest_ff));

   sqfs_div #(
      .W (VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rest_ff),
      .divisor  (sq_ff[VALUE_WIDTH-1:0]),  // sq <= rest here, so it fits
      .done     (div_done),
      .quot     (div_quot),
      .rem_zero (div_rem_zero)
   );

   always_comb begin
      state_in        = state_ff;
      rest_in         = rest_ff;
      d_in            = d_ff;
      sq_in           = sq_ff;
      outside_in      = outside_ff;
      rsp_strobe_in   = 1'b0;
      rsp_factor_in   = rsp_factor_ff;
      rsp_radicand_in = rsp_radicand_ff;
      div_start       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rest_in    = req_ext[VALUE_WIDTH-1:0];
               d_in       = DW'(FIRST_DIVISOR);
               outside_in = DW'(1);
               state_in   = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in    = mul_p;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sq_fits) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               // loop ends: rest is the square-free part (0 and 1 land here)
               rsp_strobe_in   = 1'b1;
               rsp_factor_in   = factor_ext[FACTOR_W-1:0];
               rsp_radicand_in = radicand_ext[RADICAND_W-1:0];
               state_in        = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_rem_zero) begin
                  // d*d divides: strip it and keep the same d
                  rest_in  = div_quot;
                  state_in = ST_SCALE;
               end else begin
                  d_in     = d_ff + 1'b1;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SCALE: begin
            outside_in = mul_p[DW-1:0];
            state_in   = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rest_ff         <= rest_in;
      d_ff            <= d_in;
      sq_ff           <= sq_in;
      outside_ff      <= outside_in;
      rsp_factor_ff   <= rsp_factor_in;
      rsp_radicand_ff <= rsp_radicand_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_outside_factor  = rsp_factor_ff;
   assign rsp_inside_radicand = rsp_radicand_ff;

endmodule

FILE: sv/sqfs_checker.sv
// ----------------------------------------------------------------------------
// sqfs_checker: port-level checks for square_free_split
// Ties busy and the response strobe to the transaction sequence.
// ----------------------------------------------------------------------------
module sqfs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted transaction");

   // a response only follows a busy period
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response strobe without a transaction in flight");

   // the block goes idle exactly when it responds
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a response");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while still busy");

   // one response per transaction
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe repeated");

endmodule

bind square_free_split sqfs_checker u_sqfs_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);
